// ----- hw/rtl/srarq_pkg.sv -----
// shared types, codes and helpers for the selective-repeat arq window block
`timescale 1ns / 1ps
`default_nettype none
package srarq_pkg;

  localparam int SEQ_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int DUR_W   = 16;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW  = 16;

  localparam logic [CNT_W-1:0] WINDOW_CNT   = CNT_W'(WINDOW);
  localparam logic [SEQ_W-1:0] WINDOW_SEQ   = SEQ_W'(WINDOW);
  localparam logic [DUR_W-1:0] DATA_TO_RST  = 16'd3000;
  localparam logic [DUR_W-1:0] ACK_TO_RST   = 16'd1000;

  // event codes
  localparam logic [OP_W-1:0] OP_PKT_READY  = 3'd0;
  localparam logic [OP_W-1:0] OP_PHY_READY  = 3'd1;
  localparam logic [OP_W-1:0] OP_FRAME_RX   = 3'd2;
  localparam logic [OP_W-1:0] OP_ACK_TMO    = 3'd3;
  localparam logic [OP_W-1:0] OP_DATA_TMO   = 3'd4;

  // frame kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SEND       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START_DATA = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP_DATA  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_START_ACK  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP_ACK   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STORE      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DELIVER    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_STATUS     = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TO  = 2'd1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SET_LINE,
    CMD_PKT_STORE,
    CMD_SEND,
    CMD_START_DATA,
    CMD_STOP_ACK,
    CMD_START_ACK,
    CMD_RX_STORE,
    CMD_DELIVER,
    CMD_STOP_DATA,
    CMD_STATUS
  } cmd_op_t;

  // where the sequence number of an outgoing frame comes from
  typedef enum logic [1:0] {
    SRC_TX,
    SRC_ACK_NEXT,
    SRC_OLDEST
  } seq_src_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [KIND_W-1:0] kind;
    seq_src_t          src;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              ok;
    logic [KIND_W-1:0] kind;
    logic              seq_eq_ne;
    logic              rx_in_win;
    logic              seq_marked;
    logic              ne_marked;
    logic              nak_in_win;
    logic              ack_in_win;
    logic              cnt_full;
    logic              nak_allowed;
    logic              out_free;
  } dp_stat_t;

  // circular window membership, lo inclusive, hi exclusive
  function automatic logic in_window(input logic [SEQ_W-1:0] lo,
                                     input logic [SEQ_W-1:0] x,
                                     input logic [SEQ_W-1:0] hi);
    return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
           ((x < hi) && (hi < lo));
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/srarq_dp.sv -----
// window state, config registers, arrival marks and the result register
`timescale 1ns / 1ps
`default_nettype none
module srarq_dp import srarq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctl_cmd_t             ctl,
  output dp_stat_t                  stat,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic                 in_ok,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [SEQ_W-1:0]     in_seq,
  input  wire logic [SEQ_W-1:0]     in_ack,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [DUR_W-1:0]     cfg_val,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [ACT_W-1:0]          out_action,
  output logic [KIND_W-1:0]         out_kind,
  output logic [SEQ_W-1:0]          out_seq,
  output logic [SEQ_W-1:0]          out_ack,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [DUR_W-1:0]          out_dur,
  output logic                      out_net,
  output logic                      out_last
);

  logic [DUR_W-1:0]  data_to_r, ack_to_r;
  logic [SEQ_W-1:0]  ou_r, nts_r, ne_r, rl_r, tx_seq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WINDOW-1:0] marks_r;
  logic              nak_r, line_r;

  logic [OP_W-1:0]   op_r;
  logic              ok_r;
  logic [KIND_W-1:0] kind_r;
  logic [SEQ_W-1:0]  seq_r, ack_r;

  logic              out_valid_r, out_net_r, out_last_r;
  logic [ACT_W-1:0]  out_action_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SEQ_W-1:0]  out_seq_r, out_ack_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [DUR_W-1:0]  out_dur_r;

  logic              emit;
  logic [ACT_W-1:0]  r_action;
  logic [KIND_W-1:0] r_kind;
  logic [SEQ_W-1:0]  r_seq, r_ack, tx_sel, ack_next;
  logic [SLOT_W-1:0] r_slot;
  logic [DUR_W-1:0]  r_dur;
  logic              r_net, r_last;

  assign ack_next = ack_r + SEQ_W'(1);

  always_comb begin
    unique case (ctl.src)
      SRC_TX:       tx_sel = tx_seq_r;
      SRC_ACK_NEXT: tx_sel = ack_next;
      SRC_OLDEST:   tx_sel = ou_r;
      default:      tx_sel = tx_seq_r;
    endcase
  end

  // result fields for the command at hand
  always_comb begin
    emit     = 1'b1;
    r_action = ACT_STATUS;
    r_kind   = '0;
    r_seq    = '0;
    r_ack    = '0;
    r_slot   = '0;
    r_dur    = '0;
    r_net    = 1'b0;
    r_last   = 1'b0;
    unique case (ctl.op)
      CMD_PKT_STORE: begin
        r_action = ACT_STORE;
        r_slot   = nts_r[SLOT_W-1:0];
      end
      CMD_SEND: begin
        r_action = ACT_SEND;
        r_kind   = ctl.kind;
        r_ack    = ne_r - SEQ_W'(1);
        if (ctl.kind == KIND_DATA) begin
          r_seq  = tx_sel;
          r_slot = tx_sel[SLOT_W-1:0];
        end
      end
      CMD_START_DATA: begin
        r_action = ACT_START_DATA;
        r_slot   = tx_seq_r[SLOT_W-1:0];
        r_dur    = data_to_r;
      end
      CMD_STOP_ACK:  r_action = ACT_STOP_ACK;
      CMD_START_ACK: begin
        r_action = ACT_START_ACK;
        r_dur    = ack_to_r;
      end
      CMD_RX_STORE: begin
        r_action = ACT_STORE;
        r_slot   = seq_r[SLOT_W-1:0];
      end
      CMD_DELIVER: begin
        r_action = ACT_DELIVER;
        r_slot   = ne_r[SLOT_W-1:0];
      end
      CMD_STOP_DATA: begin
        r_action = ACT_STOP_DATA;
        r_slot   = ou_r[SLOT_W-1:0];
      end
      CMD_STATUS: begin
        r_net  = (cnt_r < WINDOW_CNT) && line_r;
        r_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_to_r <= DATA_TO_RST;
      ack_to_r  <= ACK_TO_RST;
      ou_r      <= '0;
      nts_r     <= '0;
      ne_r      <= '0;
      rl_r      <= WINDOW_SEQ;
      cnt_r     <= '0;
      marks_r   <= '0;
      nak_r     <= 1'b1;
      line_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_DATA_TO) data_to_r <= cfg_val;
        if (cfg_idx == CFG_ACK_TO)  ack_to_r  <= cfg_val;
      end
      unique case (ctl.op)
        CMD_SET_LINE: line_r <= 1'b1;
        CMD_PKT_STORE: begin
          cnt_r <= cnt_r + CNT_W'(1);
          nts_r <= nts_r + SEQ_W'(1);
        end
        CMD_SEND: begin
          line_r <= 1'b0;
          if (ctl.kind == KIND_NAK) nak_r <= 1'b0;
        end
        CMD_RX_STORE: marks_r[seq_r[SLOT_W-1:0]] <= 1'b1;
        CMD_DELIVER: begin
          marks_r[ne_r[SLOT_W-1:0]] <= 1'b0;
          nak_r <= 1'b1;
          ne_r  <= ne_r + SEQ_W'(1);
          rl_r  <= rl_r + SEQ_W'(1);
        end
        CMD_STOP_DATA: begin
          if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
          ou_r <= ou_r + SEQ_W'(1);
        end
        default: ;
      endcase
    end
  end

  // latched event and frame fields, payload only
  always_ff @(posedge clk) begin
    if (ctl.op == CMD_LATCH) begin
      op_r   <= in_op;
      ok_r   <= in_ok;
      kind_r <= in_kind;
      seq_r  <= in_seq;
      ack_r  <= in_ack;
    end
    if (ctl.op == CMD_PKT_STORE) tx_seq_r <= nts_r;
    if (ctl.op == CMD_SEND)      tx_seq_r <= tx_sel;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r <= r_action;
      out_kind_r   <= r_kind;
      out_seq_r    <= r_seq;
      out_ack_r    <= r_ack;
      out_slot_r   <= r_slot;
      out_dur_r    <= r_dur;
      out_net_r    <= r_net;
      out_last_r   <= r_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_kind   = out_kind_r;
  assign out_seq    = out_seq_r;
  assign out_ack    = out_ack_r;
  assign out_slot   = out_slot_r;
  assign out_dur    = out_dur_r;
  assign out_net    = out_net_r;
  assign out_last   = out_last_r;

  always_comb begin
    stat.op          = op_r;
    stat.ok          = ok_r;
    stat.kind        = kind_r;
    stat.seq_eq_ne   = (seq_r == ne_r);
    stat.rx_in_win   = in_window(ne_r, seq_r, rl_r);
    stat.seq_marked  = marks_r[seq_r[SLOT_W-1:0]];
    stat.ne_marked   = marks_r[ne_r[SLOT_W-1:0]];
    stat.nak_in_win  = in_window(ou_r, ack_next, nts_r);
    stat.ack_in_win  = in_window(ou_r, ack_r, nts_r);
    stat.cnt_full    = (cnt_r >= WINDOW_CNT);
    stat.nak_allowed = nak_r;
    stat.out_free    = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/srarq_ctrl.sv -----
// sequencer that walks one event through its run of actions
`timescale 1ns / 1ps
`default_nettype none
module srarq_ctrl import srarq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TX_SEND,
    S_TX_START,
    S_TX_STOP,
    S_RX_MARK,
    S_DLV_CHECK,
    S_DLV_ACK,
    S_ACK_SCAN,
    S_STATUS
  } state_t;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [KIND_W-1:0] tx_kind_r, tx_kind_nxt;
  seq_src_t          tx_src_r, tx_src_nxt;
  cmd_op_t           op;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    tx_kind_nxt = tx_kind_r;
    tx_src_nxt  = tx_src_r;
    op          = CMD_NONE;
    if (state_r == S_IDLE) begin
      if (in_valid) begin
        op        = CMD_LATCH;
        state_nxt = S_DISPATCH;
      end
    end else if (stat.out_free) begin
      unique case (state_r)
        S_DISPATCH: begin
          state_nxt = S_STATUS;
          unique case (stat.op)
            OP_PKT_READY: begin
              if (!stat.cnt_full) begin
                op          = CMD_PKT_STORE;
                tx_kind_nxt = KIND_DATA;
                tx_src_nxt  = SRC_TX;
                ret_nxt     = S_STATUS;
                state_nxt   = S_TX_SEND;
              end
            end
            OP_PHY_READY: op = CMD_SET_LINE;
            OP_FRAME_RX: begin
              if (!stat.ok) begin
                if (stat.nak_allowed) begin
                  tx_kind_nxt = KIND_NAK;
                  ret_nxt     = S_STATUS;
                  state_nxt   = S_TX_SEND;
                end
              end else if (stat.kind == KIND_DATA) begin
                state_nxt = S_RX_MARK;
                if (!stat.seq_eq_ne && stat.nak_allowed) begin
                  tx_kind_nxt = KIND_NAK;
                  ret_nxt     = S_RX_MARK;
                  state_nxt   = S_TX_SEND;
                end else if (stat.seq_eq_ne) begin
                  op = CMD_START_ACK;
                end
              end else if (stat.kind == KIND_NAK && stat.nak_in_win) begin
                tx_kind_nxt = KIND_DATA;
                tx_src_nxt  = SRC_ACK_NEXT;
                ret_nxt     = S_ACK_SCAN;
                state_nxt   = S_TX_SEND;
              end else begin
                state_nxt = S_ACK_SCAN;
              end
            end
            OP_ACK_TMO: begin
              tx_kind_nxt = KIND_ACK;
              ret_nxt     = S_STATUS;
              state_nxt   = S_TX_SEND;
            end
            OP_DATA_TMO: begin
              tx_kind_nxt = KIND_DATA;
              tx_src_nxt  = SRC_OLDEST;
              ret_nxt     = S_STATUS;
              state_nxt   = S_TX_SEND;
            end
            default: ;
          endcase
        end
        S_TX_SEND: begin
          op        = CMD_SEND;
          state_nxt = (tx_kind_r == KIND_DATA) ? S_TX_START : S_TX_STOP;
        end
        S_TX_START: begin
          op        = CMD_START_DATA;
          state_nxt = S_TX_STOP;
        end
        S_TX_STOP: begin
          op        = CMD_STOP_ACK;
          state_nxt = ret_r;
        end
        S_RX_MARK: begin
          if (stat.rx_in_win && !stat.seq_marked) begin
            op        = CMD_RX_STORE;
            state_nxt = S_DLV_CHECK;
          end else begin
            state_nxt = S_ACK_SCAN;
          end
        end
        S_DLV_CHECK: begin
          if (stat.ne_marked) begin
            op        = CMD_DELIVER;
            state_nxt = S_DLV_ACK;
          end else begin
            state_nxt = S_ACK_SCAN;
          end
        end
        S_DLV_ACK: begin
          op        = CMD_START_ACK;
          state_nxt = S_DLV_CHECK;
        end
        S_ACK_SCAN: begin
          if (stat.ack_in_win) begin
            op = CMD_STOP_DATA;
          end else begin
            state_nxt = S_STATUS;
          end
        end
        S_STATUS: begin
          op        = CMD_STATUS;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_STATUS;
      tx_kind_r <= KIND_DATA;
      tx_src_r  <= SRC_TX;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      tx_kind_r <= tx_kind_nxt;
      tx_src_r  <= tx_src_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl.op   = op;
    ctl.kind = tx_kind_r;
    ctl.src  = tx_src_r;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/selective_repeat_arq_window.sv -----
// top level of the selective-repeat arq window controller
`timescale 1ns / 1ps
`default_nettype none
// Window control for a selective-repeat ARQ link with 5-bit sequence numbers
// and a 16-frame window. Each input beat is one event (packet ready, physical
// layer ready, received frame, ack timeout, data timeout); the block answers
// with a run of action beats (send DATA/ACK/NAK, start or stop a timer, store
// or deliver a payload slot) that always ends in one status beat with tlast
// set, carrying the network-enable flag. A sequencer issues at most one action
// per clock into a single output register, and none while that register is
// full and unaccepted. Besides its actions, an event passes through the accept
// step, the dispatch step when it issues no action itself, and the decision
// steps that close the store, deliver and release steps. The longest run, an
// in-order received frame that delivers and releases a full window, is 3*16+3
// beats. A new event is taken as soon as the status beat sits in the output
// register. The receive marks are flip-flops cleared by reset, so no clearing
// pass is needed.
// Configuration writes (0 data timeout, 1 ack timeout, other indexes ignored)
// are always taken and must only come while the block is idle.
module selective_repeat_arq_window import srarq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: frame_seq[4:0], ack_num[9:5], zero fill
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,
  // in_tuser: operation[2:0], frame_ok[3], frame_kind[5:4]
  input  wire logic [5:0]           in_tuser,
  // out_tdata: send_seq[4:0], send_ack[9:5], slot[13:10], duration[29:14],
  //            net_enable[30], zero fill
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,
  // out_tuser: action[2:0], send_kind[4:3]
  output logic [4:0]                out_tuser,
  output logic                      out_tlast,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_data
);

  ctl_cmd_t          ctl;
  dp_stat_t          stat;
  logic [ACT_W-1:0]  action;
  logic [KIND_W-1:0] send_kind;
  logic [SEQ_W-1:0]  send_seq, send_ack;
  logic [SLOT_W-1:0] slot;
  logic [DUR_W-1:0]  duration;
  logic              net_enable;

  // register writes never stall
  assign cfg_ready = 1'b1;

  srarq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  srarq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_op      (in_tuser[2:0]),
    .in_ok      (in_tuser[3]),
    .in_kind    (in_tuser[5:4]),
    .in_seq     (in_tdata[4:0]),
    .in_ack     (in_tdata[9:5]),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_action (action),
    .out_kind   (send_kind),
    .out_seq    (send_seq),
    .out_ack    (send_ack),
    .out_slot   (slot),
    .out_dur    (duration),
    .out_net    (net_enable),
    .out_last   (out_tlast)
  );

  // pack result fields, lowest field first
  assign out_tdata = {1'b0, net_enable, duration, slot, send_ack, send_seq};
  assign out_tuser = {send_kind, action};

endmodule
`default_nettype wire

// ----- hw/rtl/srarq_checker.sv -----
// port-level checks for the arq window block and their bind
`timescale 1ns / 1ps
`default_nettype none
module srarq_checker import srarq_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [4:0]  out_tuser,
  input wire logic        out_tlast
);

  // tlast marks the status beat and nothing else
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[2:0] == ACT_STATUS)))
    else $error("tlast does not match status beat");

  // one event at a time: after an input beat the input side closes
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after a beat");

  // only timer starts carry a duration
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] != ACT_START_DATA &&
     out_tuser[2:0] != ACT_START_ACK) |-> (out_tdata[29:14] == '0))
    else $error("duration on a non timer start beat");

  // ack and nak frames go out with sequence and slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] == ACT_SEND && out_tuser[4:3] != KIND_DATA)
    |-> (out_tdata[4:0] == '0 && out_tdata[13:10] == '0))
    else $error("control frame carries a sequence number");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
    (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result beat changed");

endmodule

bind selective_repeat_arq_window srarq_checker u_srarq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
